// File: hdl/utrb_pkg.sv
// Shared types and constants for the UART transmit ring and receive line buffer.
package utrb_pkg;

    localparam logic [7:0] CHAR_CR = 8'd13;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_TX_RDY  = 2'd1,
        CMD_RX_BYTE = 2'd2,
        CMD_CONSUME = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        KIND_PUSHED      = 4'd0,
        KIND_PUSH_FULL   = 4'd1,
        KIND_TX_BYTE     = 4'd2,
        KIND_TX_EMPTY    = 4'd3,
        KIND_RX_STORED   = 4'd4,
        KIND_RX_DROPPED  = 4'd5,
        KIND_LINE_MARKED = 4'd6,
        KIND_LINE_BYTE   = 4'd7,
        KIND_EMPTY_LINE  = 4'd8,
        KIND_NO_LINE     = 4'd9
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic line_step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
        logic consume_line;
        logic line_end;
    } t_ctrl_stat;

endpackage

// File: hdl/utrb_ctrl.sv
// Sequencer that accepts items and steps the datapath through single results and line dumps.
module utrb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  utrb_pkg::t_ctrl_stat  i_stat,
    output utrb_pkg::t_ctrl_cmd   o_cmd
);
    import utrb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    if (i_stat.consume_line) begin
                        o_cmd.line_step = 1'b1;
                        n_state = i_stat.line_end ? S_IDLE : S_LINE;
                    end else begin
                        o_cmd.exec = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_LINE: begin
                if (i_stat.out_free) begin
                    o_cmd.line_step = 1'b1;
                    if (i_stat.line_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/utrb_dp.sv
// Datapath with the transmit ring, the line store, their counters and the result register.
module utrb_dp #(
    parameter int TX_DEPTH = 64,
    parameter int RX_DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_cmd,
    input  logic [7:0]            i_byte_in,
    input  utrb_pkg::t_ctrl_cmd   i_ctl,
    output utrb_pkg::t_ctrl_stat  o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [3:0]            o_kind,
    output logic [7:0]            o_byte_out,
    output logic [5:0]            o_line_length,
    output logic [6:0]            o_tx_free_slots,
    output logic                  o_last
);
    import utrb_pkg::*;

    localparam int TW = $clog2(TX_DEPTH);
    localparam int FW = $clog2(TX_DEPTH + 1);
    localparam int RW = $clog2(RX_DEPTH);
    localparam int CW = $clog2(RX_DEPTH + 1);

    logic [7:0]    tx_ring [TX_DEPTH];
    logic [7:0]    rx_line [RX_DEPTH];

    t_cmd          r_cmd;
    logic [7:0]    r_din;
    logic [TW-1:0] r_tx_wr, n_tx_wr;
    logic [TW-1:0] r_tx_rd, n_tx_rd;
    logic [FW-1:0] r_free, n_free;
    logic [CW-1:0] r_count, n_count;
    logic          r_ready, n_ready;
    logic [RW-1:0] r_idx, n_idx;
    logic [7:0]    r_tx_q, r_rx_q;

    logic          r_out_valid, n_out_valid;
    t_kind         r_kind, n_kind;
    logic [7:0]    r_byte, n_byte;
    logic [5:0]    r_len, n_len;
    logic [6:0]    r_free_out, n_free_out;
    logic          r_last, n_last;

    logic          tx_we, rx_we;
    logic          tx_full, tx_empty, rx_full, out_free, line_end;
    logic [FW+6:0] free_ext;
    logic [CW+5:0] len_ext;

    assign tx_full  = (r_free == '0);
    assign tx_empty = (r_free == FW'(TX_DEPTH));
    assign rx_full  = (r_count == CW'(RX_DEPTH));
    assign out_free = !r_out_valid || !i_out_stall;
    assign line_end = ((CW'(r_idx) + CW'(1)) == r_count);

    assign o_stat.out_free     = out_free;
    assign o_stat.consume_line = (r_cmd == CMD_CONSUME) && r_ready && (r_count != '0);
    assign o_stat.line_end     = line_end;

    always_comb begin
        n_tx_wr     = r_tx_wr;
        n_tx_rd     = r_tx_rd;
        n_free      = r_free;
        n_count     = r_count;
        n_ready     = r_ready;
        n_idx       = r_idx;
        n_kind      = r_kind;
        n_byte      = r_byte;
        n_last      = r_last;
        tx_we       = 1'b0;
        rx_we       = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;

        if (i_ctl.exec) begin
            n_out_valid = 1'b1;
            n_byte      = 8'd0;
            n_last      = 1'b1;
            unique case (r_cmd)
                CMD_PUSH: begin
                    if (tx_full) begin
                        n_kind = KIND_PUSH_FULL;
                    end else begin
                        tx_we   = 1'b1;
                        n_tx_wr = (r_tx_wr == TW'(TX_DEPTH - 1)) ? '0 : r_tx_wr + TW'(1);
                        n_free  = r_free - FW'(1);
                        n_kind  = KIND_PUSHED;
                    end
                end
                CMD_TX_RDY: begin
                    if (tx_empty) begin
                        n_kind = KIND_TX_EMPTY;
                    end else begin
                        n_tx_rd = (r_tx_rd == TW'(TX_DEPTH - 1)) ? '0 : r_tx_rd + TW'(1);
                        n_free  = r_free + FW'(1);
                        n_kind  = KIND_TX_BYTE;
                        n_byte  = r_tx_q;
                    end
                end
                CMD_RX_BYTE: begin
                    if (r_din == CHAR_CR) begin
                        n_ready = 1'b1;
                        n_kind  = KIND_LINE_MARKED;
                    end else if (!rx_full) begin
                        rx_we   = 1'b1;
                        n_count = r_count + CW'(1);
                        n_kind  = KIND_RX_STORED;
                    end else begin
                        n_kind = KIND_RX_DROPPED;
                    end
                end
                CMD_CONSUME: begin
                    if (!r_ready) begin
                        n_kind = KIND_NO_LINE;
                    end else begin
                        n_ready = 1'b0;
                        n_count = '0;
                        n_kind  = KIND_EMPTY_LINE;
                    end
                end
                default: begin
                    n_kind = KIND_NO_LINE;
                end
            endcase
        end else if (i_ctl.line_step) begin
            n_out_valid = 1'b1;
            n_kind      = KIND_LINE_BYTE;
            n_byte      = r_rx_q;
            n_last      = line_end;
            if (line_end) begin
                n_idx   = '0;
                n_count = '0;
                n_ready = 1'b0;
            end else begin
                n_idx = r_idx + RW'(1);
            end
        end

        free_ext = {7'd0, n_free};
        len_ext  = {6'd0, n_count};
        if (i_ctl.exec) begin
            n_free_out = free_ext[6:0];
            n_len      = len_ext[5:0];
        end else if (i_ctl.line_step) begin
            n_free_out = free_ext[6:0];
            n_len      = 6'd0;
        end else begin
            n_free_out = r_free_out;
            n_len      = r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            tx_ring[r_tx_wr] <= r_din;
        end
        r_tx_q <= tx_ring[n_tx_rd];
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            rx_line[r_count[RW-1:0]] <= r_din;
        end
        r_rx_q <= rx_line[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_wr     <= '0;
            r_tx_rd     <= '0;
            r_free      <= FW'(TX_DEPTH);
            r_count     <= '0;
            r_ready     <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_tx_wr     <= n_tx_wr;
            r_tx_rd     <= n_tx_rd;
            r_free      <= n_free;
            r_count     <= n_count;
            r_ready     <= n_ready;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd <= t_cmd'(i_cmd);
            r_din <= i_byte_in;
        end
        r_kind     <= n_kind;
        r_byte     <= n_byte;
        r_len      <= n_len;
        r_free_out <= n_free_out;
        r_last     <= n_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_byte_out      = r_byte;
    assign o_line_length   = r_len;
    assign o_tx_free_slots = r_free_out;
    assign o_last          = r_last;

endmodule

// File: hdl/uart_tx_ring_and_rx_line_buffer_unit.sv
// Top level of the UART transmit ring and receive line buffer engine.
// An item is taken while the sequencer is idle and executed once the output register is free;
// its result is then registered there. A consume of a ready empty line gives one result,
// and of a ready line of n bytes gives n results on consecutive free output cycles.
// Reset is synchronous and active low; it clears pointers, counts and the line-ready flag,
// and the storage arrays themselves are not cleared.
module uart_tx_ring_and_rx_line_buffer_unit #(
    parameter int TX_DEPTH = 64,
    parameter int RX_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_byte_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_kind,
    output logic [7:0] o_byte_out,
    output logic [5:0] o_line_length,
    output logic [6:0] o_tx_free_slots,
    output logic       o_last
);
    import utrb_pkg::*;

    t_ctrl_cmd  ctl;
    t_ctrl_stat stat;

    utrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (ctl)
    );

    utrb_dp #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (i_cmd),
        .i_byte_in       (i_byte_in),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_byte_out      (o_byte_out),
        .o_line_length   (o_line_length),
        .o_tx_free_slots (o_tx_free_slots),
        .o_last          (o_last)
    );

endmodule

// File: bench/uart_tx_ring_and_rx_line_buffer_unit_chk.sv
// Checker that predicts and compares every result of the UART ring and line buffer engine.
module uart_tx_ring_and_rx_line_buffer_unit_chk #(
    parameter int TX_DEPTH = 64,
    parameter int RX_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_byte_in,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [3:0] i_kind,
    input  logic [7:0] i_byte_out,
    input  logic [5:0] i_line_length,
    input  logic [6:0] i_tx_free_slots,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results_checked
);
    import utrb_pkg::*;

    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        logic [5:0] line_len;
        logic [6:0] free_slots;
        logic       last_flag;
    } t_uart_result;

    logic [7:0] tx_ring [TX_DEPTH];
    logic [$clog2(TX_DEPTH)-1:0] tx_wr_ptr;
    logic [$clog2(TX_DEPTH)-1:0] tx_rd_ptr;
    logic [6:0] tx_free;
    logic [7:0] rx_line [RX_DEPTH];
    logic [5:0] rx_len;
    logic       line_ready;

    t_uart_result results_due[$];
    t_uart_result due;
    int fail_count = 0;
    int results_checked = 0;

    task automatic queue_result(input t_kind kind, input logic [7:0] data,
                                input logic last_flag);
        results_due.push_back('{kind: kind, data: data, line_len: rx_len,
                                free_slots: tx_free, last_flag: last_flag});
    endtask

    task automatic predict_buffer_step(input t_cmd cmd, input logic [7:0] data);
        int n;
        case (cmd)
            CMD_PUSH: begin
                if (tx_free == 0) begin
                    queue_result(KIND_PUSH_FULL, 8'd0, 1'b1);
                end else begin
                    tx_ring[tx_wr_ptr] = data;
                    tx_wr_ptr = tx_wr_ptr + 1'b1;
                    tx_free = tx_free - 1'b1;
                    queue_result(KIND_PUSHED, 8'd0, 1'b1);
                end
            end
            CMD_TX_RDY: begin
                if (tx_free >= TX_DEPTH) begin
                    queue_result(KIND_TX_EMPTY, 8'd0, 1'b1);
                end else begin
                    n = int'(tx_rd_ptr);
                    tx_rd_ptr = tx_rd_ptr + 1'b1;
                    tx_free = tx_free + 1'b1;
                    queue_result(KIND_TX_BYTE, tx_ring[n], 1'b1);
                end
            end
            CMD_RX_BYTE: begin
                if (data == CHAR_CR) begin
                    line_ready = 1'b1;
                    queue_result(KIND_LINE_MARKED, 8'd0, 1'b1);
                end else if (rx_len < RX_DEPTH) begin
                    rx_line[rx_len[$clog2(RX_DEPTH)-1:0]] = data;
                    rx_len = rx_len + 1'b1;
                    queue_result(KIND_RX_STORED, 8'd0, 1'b1);
                end else begin
                    queue_result(KIND_RX_DROPPED, 8'd0, 1'b1);
                end
            end
            default: begin
                if (!line_ready) begin
                    queue_result(KIND_NO_LINE, 8'd0, 1'b1);
                end else begin
                    n = int'(rx_len);
                    line_ready = 1'b0;
                    rx_len = '0;
                    if (n == 0) begin
                        queue_result(KIND_EMPTY_LINE, 8'd0, 1'b1);
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            queue_result(KIND_LINE_BYTE, rx_line[i], i == n - 1);
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_wr_ptr = '0;
            tx_rd_ptr = '0;
            tx_free = 7'(TX_DEPTH);
            rx_len = '0;
            line_ready = 1'b0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_buffer_step(t_cmd'(i_cmd), i_byte_in);
            end
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result of kind %0d arrived with no item outstanding", i_kind);
                    fail_count++;
                end else begin
                    due = results_due.pop_front();
                    compare_field("kind", due.kind, i_kind);
                    compare_field("byte_out", due.data, i_byte_out);
                    compare_field("line_length", due.line_len, i_line_length);
                    compare_field("tx_free_slots", due.free_slots, i_tx_free_slots);
                    compare_field("last", due.last_flag, i_last);
                    results_checked++;
                end
            end
        end
        o_pending <= results_due.size();
        o_fail_count <= fail_count;
        o_results_checked <= results_checked;
    end

endmodule

// File: bench/uart_tx_ring_and_rx_line_buffer_unit_tb.sv
// Stimulus, pacing and verdict for the UART transmit ring and receive line buffer engine.
module uart_tx_ring_and_rx_line_buffer_unit_tb;
    import utrb_pkg::*;

    localparam int LONG_HOLD = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_cmd;
    logic [7:0] i_byte_in;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [3:0] o_kind;
    logic [7:0] o_byte_out;
    logic [5:0] o_line_length;
    logic [6:0] o_tx_free_slots;
    logic       o_last;

    int fail_count;
    int pending;
    int results_checked;
    int send_idle_pct = 7;
    int recv_idle_pct = 73;
    int items_sent = 0;
    int idle_cycles = 0;
    int hold_requests = 0;
    int holds_served = 0;

    uart_tx_ring_and_rx_line_buffer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_byte_in       (i_byte_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_byte_out      (o_byte_out),
        .o_line_length   (o_line_length),
        .o_tx_free_slots (o_tx_free_slots),
        .o_last          (o_last)
    );

    uart_tx_ring_and_rx_line_buffer_unit_chk chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_byte_in         (i_byte_in),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_kind            (o_kind),
        .i_byte_out        (o_byte_out),
        .i_line_length     (o_line_length),
        .i_tx_free_slots   (o_tx_free_slots),
        .i_last            (o_last),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results_checked (results_checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else begin
                i_out_stall <= $urandom_range(99) < recv_idle_pct;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_item(input t_cmd cmd, input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_byte_in <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_line(input int len);
        for (int i = 0; i < len; i++) begin
            send_item(CMD_RX_BYTE, 8'($urandom_range(255)));
        end
        send_item(CMD_RX_BYTE, CHAR_CR);
        if ($urandom_range(3) == 0) send_item(CMD_RX_BYTE, 8'($urandom_range(255)));
        send_item(CMD_CONSUME, 8'($urandom_range(255)));
        if ($urandom_range(3) == 0) send_item(CMD_CONSUME, 8'($urandom_range(255)));
    endtask

    task automatic send_episodes(input int item_goal);
        int pick;
        int pushes;
        while (items_sent < item_goal) begin
            pick = $urandom_range(9);
            if (pick < 4) begin
                send_line(($urandom_range(4) == 0) ? $urandom_range(28, 36)
                                                   : $urandom_range(0, 6));
            end else if (pick < 8) begin
                pushes = $urandom_range(1, 8);
                repeat (pushes) send_item(CMD_PUSH, 8'($urandom_range(255)));
                repeat ($urandom_range(0, pushes + 2)) begin
                    send_item(CMD_TX_RDY, 8'($urandom_range(255)));
                end
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    send_item(t_cmd'($urandom_range(3)), 8'($urandom_range(255)));
                end
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_cmd <= CMD_PUSH;
        i_byte_in <= 8'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(CMD_CONSUME, 8'h00);
        send_item(CMD_TX_RDY, 8'hFF);
        send_item(CMD_PUSH, 8'h00);
        send_item(CMD_PUSH, 8'hFF);
        send_item(CMD_TX_RDY, 8'h00);
        send_item(CMD_TX_RDY, 8'hFF);
        send_item(CMD_RX_BYTE, CHAR_CR);
        send_item(CMD_CONSUME, 8'hFF);
        send_item(CMD_RX_BYTE, 8'h00);
        send_item(CMD_RX_BYTE, 8'hFF);
        send_item(CMD_RX_BYTE, 8'h0C);
        send_item(CMD_RX_BYTE, 8'h0E);
        send_item(CMD_RX_BYTE, CHAR_CR);
        send_item(CMD_RX_BYTE, 8'h55);
        send_item(CMD_RX_BYTE, CHAR_CR);
        send_item(CMD_CONSUME, 8'h00);
        send_item(CMD_CONSUME, 8'hAA);

        send_episodes(50);
        wait_drained();

        send_idle_pct = 73;
        recv_idle_pct = 7;
        send_line(35);
        send_episodes(95);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        repeat (66) send_item(CMD_PUSH, 8'($urandom_range(255)));
        send_episodes(180);
        wait_drained();

        repeat (10) @(posedge i_clk);
        $display("Ran %0d items and checked %0d results across three pacing phases,",
                 items_sent, results_checked);
        $display("including a full transmit ring, an overflowing line and a long output hold.");
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
